// ===== rtl/cpsg_pkg.sv =====
// Shared constants, register codes and arithmetic helpers of the circle segment generator.
package cpsg_pkg;

   // Phase, coordinate and rotation precision
   localparam int ANGLE_BITS      = 16;
   localparam int COORD_BITS      = 12;
   localparam int TRIG_ITERATIONS = 16;

   localparam int RADIUS_BITS = COORD_BITS - 1;
   localparam int OUT_BITS    = COORD_BITS + 2;

   // Configuration register fields
   localparam int STEP_COUNT_BITS = 11;
   localparam int ANGLE_INC_BITS  = 16;
   localparam int SEG_LEN_BITS    = 8;
   localparam int MODE_BITS       = 2;
   localparam int CFG_INDEX_BITS  = 3;
   localparam int CFG_DATA_BITS   = 16;

   localparam logic [CFG_INDEX_BITS-1:0] CSR_CENTER_X    = 3'd0;
   localparam logic [CFG_INDEX_BITS-1:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [CFG_INDEX_BITS-1:0] CSR_RADIUS      = 3'd2;
   localparam logic [CFG_INDEX_BITS-1:0] CSR_STEP_MODE   = 3'd3;
   localparam logic [CFG_INDEX_BITS-1:0] CSR_STEP_COUNT  = 3'd4;
   localparam logic [CFG_INDEX_BITS-1:0] CSR_ANGLE_INC   = 3'd5;
   localparam logic [CFG_INDEX_BITS-1:0] CSR_MAX_SEG_LEN = 3'd6;

   localparam logic [MODE_BITS-1:0] MODE_COUNT   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ANGLE   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_LENGTH  = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_DEFAULT = 2'd3;

   // Step computation
   localparam longint unsigned FULL_TURN = 64'd1 << ANGLE_BITS;
   localparam int INV_BITS = 30;
   localparam logic [INV_BITS-1:0] INV_TWO_PI_Q32 = 30'd683565276;
   localparam logic [ANGLE_BITS-1:0] DEFAULT_DELTA =
      ANGLE_BITS'(((FULL_TURN * 64'd683565276) / 64'd100) >> 32);
   localparam logic [STEP_COUNT_BITS-1:0] DEFAULT_COUNT   = 11'd50;
   localparam logic [SEG_LEN_BITS-1:0]    DEFAULT_SEG_LEN = 8'd7;

   // length * turn / (2 pi r) reduces to (length * inv) >> (32 - ANGLE_BITS), divided by r
   localparam int PROD_BITS    = SEG_LEN_BITS + INV_BITS;
   localparam int DVD_BITS     = PROD_BITS - (32 - ANGLE_BITS);
   localparam int DIVISOR_BITS = 11;
   localparam int CNT_BITS     = $clog2(DVD_BITS);

   // Rotation datapath
   localparam int CORDIC_BITS = 32;
   localparam logic signed [CORDIC_BITS-1:0] GAIN_Q30 = 32'sd652032874;
   localparam int MAG_BITS      = 16;
   localparam int PROD_MAG_BITS = MAG_BITS + RADIUS_BITS;
   localparam int OFF_BITS      = PROD_MAG_BITS - 15;

   // Arctangent of 2^-i in units of 2^-32 turn
   function automatic logic signed [CORDIC_BITS-1:0] cordic_atan(input logic [CNT_BITS-1:0] idx);
      logic signed [CORDIC_BITS-1:0] v;
      case (idx)
         5'd0:    v = 32'sh20000000;
         5'd1:    v = 32'sh12E4051E;
         5'd2:    v = 32'sh09FB385B;
         5'd3:    v = 32'sh051111D4;
         5'd4:    v = 32'sh028B0D43;
         5'd5:    v = 32'sh0145D7E1;
         5'd6:    v = 32'sh00A2F61E;
         5'd7:    v = 32'sh00517C55;
         5'd8:    v = 32'sh0028BE53;
         5'd9:    v = 32'sh00145F2F;
         5'd10:   v = 32'sh000A2F98;
         5'd11:   v = 32'sh000517CC;
         5'd12:   v = 32'sh00028BE6;
         5'd13:   v = 32'sh000145F3;
         5'd14:   v = 32'sh0000A2F9;
         5'd15:   v = 32'sh0000517C;
         5'd16:   v = 32'sh000028BE;
         5'd17:   v = 32'sh0000145F;
         5'd18:   v = 32'sh00000A2F;
         5'd19:   v = 32'sh00000517;
         5'd20:   v = 32'sh0000028B;
         5'd21:   v = 32'sh00000145;
         5'd22:   v = 32'sh000000A2;
         5'd23:   v = 32'sh00000051;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Round a Q30 value to Q1.15, clamp to +-1.0, return {sign, magnitude}
   function automatic logic [MAG_BITS:0] round_q15_mag(input logic signed [CORDIC_BITS-1:0] v);
      logic signed [CORDIC_BITS:0] sum;
      logic signed [17:0] rq;
      logic signed [17:0] cl;
      logic [17:0] ab;
      sum = $signed({v[CORDIC_BITS-1], v}) + 33'sd16384;
      rq  = sum[CORDIC_BITS:15];
      if (rq > 18'sd32768) begin
         cl = 18'sd32768;
      end else if (rq < -18'sd32768) begin
         cl = -18'sd32768;
      end else begin
         cl = rq;
      end
      ab = cl[17] ? 18'(-cl) : 18'(cl);
      return {cl[17], ab[MAG_BITS-1:0]};
   endfunction

endpackage

// ===== rtl/circle_polyline_segment_generator_unit.sv =====
// Circle polyline segment generator: step divider, iterative rotation and serial scaling.
//
// Each request word yields one response word holding a chord of a polygon approximating
// the configured circle. A continuing segment runs 16 rotation iterations, a rounding step,
// bit-serial radius scaling (one radius bit per cycle) and the point and output states
// before the next request is taken. A restart (or the first request after a completed turn)
// also recomputes the starting point first, and in step modes 0 and 2 it runs before that
// the one-bit-per-cycle divider that produces the angle step. The response sits in an
// output register, so the next request is taken while a response still waits; the response
// register itself holds only one word. Centre and radius are sampled per request; the step
// mode takes effect only on a restart or on the first request after a completed turn.
module circle_polyline_segment_generator_unit
   import cpsg_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [OUT_BITS-1:0]       rsp_start_x,
   output logic signed [OUT_BITS-1:0]       rsp_start_y,
   output logic signed [OUT_BITS-1:0]       rsp_end_x,
   output logic signed [OUT_BITS-1:0]       rsp_end_y,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [CFG_INDEX_BITS-1:0]        csr_index,
   input  logic [CFG_DATA_BITS-1:0]         csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_TRIG  = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;
   localparam logic [2:0] ST_POINT = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   // Configuration registers
   logic [COORD_BITS-1:0]      center_x_ff, center_y_ff;
   logic [RADIUS_BITS-1:0]     radius_ff;
   logic [MODE_BITS-1:0]       mode_ff;
   logic [STEP_COUNT_BITS-1:0] count_ff;
   logic [ANGLE_INC_BITS-1:0]  incr_ff;
   logic [SEG_LEN_BITS-1:0]    seglen_ff;

   // Control state
   logic [2:0]            state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  turn_done_ff, turn_done_in;
   logic                  start_pass_ff, start_pass_in;
   logic [ANGLE_BITS:0]   angle_ff, angle_in;
   logic [ANGLE_BITS-1:0] delta_ff, delta_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [DVD_BITS-1:0]               dvd_ff, dvd_in;
   logic [DIVISOR_BITS-1:0]           div_ff, div_in;
   logic [DIVISOR_BITS-1:0]           rem_ff, rem_in;
   logic signed [CORDIC_BITS-1:0]     x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0]                        quad_ff, quad_in;
   logic [PROD_MAG_BITS-1:0]          mcx_ff, mcx_in, mcy_ff, mcy_in;
   logic [PROD_MAG_BITS-1:0]          accx_ff, accx_in, accy_ff, accy_in;
   logic                              sgnx_ff, sgnx_in, sgny_ff, sgny_in;
   logic [RADIUS_BITS-1:0]            rad_ff, rad_in;
   logic [OUT_BITS-1:0]               prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [OUT_BITS-1:0]               end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic [OUT_BITS-1:0]               ox0_ff, ox0_in, oy0_ff, oy0_in;
   logic [OUT_BITS-1:0]               ox1_ff, ox1_in, oy1_ff, oy1_in;
   logic                              olast_ff, olast_in;

   // Combinational helpers
   logic [STEP_COUNT_BITS-1:0] count_eff;
   logic [SEG_LEN_BITS-1:0]    seglen_eff;
   logic [RADIUS_BITS-1:0]     radius_div;
   logic [PROD_BITS-1:0]       seg_prod;
   logic [DIVISOR_BITS:0]      trial, trial_diff;
   logic                       qbit;
   logic [DVD_BITS-1:0]        quot_next;
   logic [ANGLE_BITS-1:0]      quot_sat;
   logic [ANGLE_BITS:0]        angle_sum;
   logic [MAG_BITS:0]          cos_rm, sin_rm;
   logic [MAG_BITS-1:0]        magx, magy;
   logic                       signx, signy;
   logic [OFF_BITS-1:0]        offx, offy;
   logic [OUT_BITS-1:0]        offx_ext, offy_ext, pt_x, pt_y;
   logic                       trig_load;
   logic [ANGLE_BITS-1:0]      trig_angle;
   logic                       out_load;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_start_x = ox0_ff;
   assign rsp_start_y = oy0_ff;
   assign rsp_end_x   = ox1_ff;
   assign rsp_end_y   = oy1_ff;
   assign rsp_last    = olast_ff;

   // Step operands with zero substitutes
   assign count_eff  = (count_ff == '0) ? DEFAULT_COUNT : count_ff;
   assign seglen_eff = (seglen_ff == '0) ? DEFAULT_SEG_LEN : seglen_ff;
   assign radius_div = (radius_ff == '0) ? RADIUS_BITS'(1) : radius_ff;
   assign seg_prod   = PROD_BITS'(seglen_eff) * PROD_BITS'(INV_TWO_PI_Q32);

   // Restoring divider, one quotient bit per cycle
   assign trial      = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign trial_diff = trial - {1'b0, div_ff};
   assign qbit       = (trial >= {1'b0, div_ff});
   assign quot_next  = {dvd_ff[DVD_BITS-2:0], qbit};

   always_comb begin
      if (quot_next == '0) begin
         quot_sat = ANGLE_BITS'(1);
      end else if (|quot_next[DVD_BITS-1:ANGLE_BITS]) begin
         quot_sat = '1;
      end else begin
         quot_sat = quot_next[ANGLE_BITS-1:0];
      end
   end

   assign angle_sum = angle_ff + {1'b0, delta_ff};

   // Rounded rotation result folded into the octant-free quadrant
   assign cos_rm = round_q15_mag(x_ff);
   assign sin_rm = round_q15_mag(y_ff);

   always_comb begin
      case (quad_ff)
         2'd0: begin
            magx = cos_rm[MAG_BITS-1:0]; signx = cos_rm[MAG_BITS];
            magy = sin_rm[MAG_BITS-1:0]; signy = sin_rm[MAG_BITS];
         end
         2'd1: begin
            magx = sin_rm[MAG_BITS-1:0]; signx = ~sin_rm[MAG_BITS];
            magy = cos_rm[MAG_BITS-1:0]; signy = cos_rm[MAG_BITS];
         end
         2'd2: begin
            magx = cos_rm[MAG_BITS-1:0]; signx = ~cos_rm[MAG_BITS];
            magy = sin_rm[MAG_BITS-1:0]; signy = ~sin_rm[MAG_BITS];
         end
         default: begin
            magx = sin_rm[MAG_BITS-1:0]; signx = sin_rm[MAG_BITS];
            magy = cos_rm[MAG_BITS-1:0]; signy = ~cos_rm[MAG_BITS];
         end
      endcase
   end

   // Point = centre +- (radius * |trig|) >> 15, truncated toward zero
   assign offx     = accx_ff[PROD_MAG_BITS-1:15];
   assign offy     = accy_ff[PROD_MAG_BITS-1:15];
   assign offx_ext = OUT_BITS'(offx);
   assign offy_ext = OUT_BITS'(offy);
   assign pt_x = OUT_BITS'(center_x_ff) + (sgnx_ff ? (~offx_ext + OUT_BITS'(1)) : offx_ext);
   assign pt_y = OUT_BITS'(center_y_ff) + (sgny_ff ? (~offy_ext + OUT_BITS'(1)) : offy_ext);

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // Sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      turn_done_in  = turn_done_ff;
      start_pass_in = start_pass_ff;
      angle_in      = angle_ff;
      delta_in      = delta_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      dvd_in        = dvd_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      quad_in       = quad_ff;
      mcx_in        = mcx_ff;
      mcy_in        = mcy_ff;
      accx_in       = accx_ff;
      accy_in       = accy_ff;
      sgnx_in       = sgnx_ff;
      sgny_in       = sgny_ff;
      rad_in        = rad_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      ox0_in        = ox0_ff;
      oy0_in        = oy0_ff;
      ox1_in        = ox1_ff;
      oy1_in        = oy1_ff;
      olast_in      = olast_ff;
      trig_load     = 1'b0;
      trig_angle    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart || turn_done_ff) begin
                  state_in = ST_PREP;
               end else begin
                  angle_in      = angle_sum;
                  trig_load     = 1'b1;
                  trig_angle    = angle_sum[ANGLE_BITS-1:0];
                  start_pass_in = 1'b0;
                  state_in      = ST_TRIG;
               end
            end
         end
         ST_PREP: begin
            // Latch the step, dividing where the mode needs it
            rem_in = '0;
            cnt_in = '0;
            case (mode_ff)
               MODE_COUNT: begin
                  dvd_in   = DVD_BITS'(FULL_TURN);
                  div_in   = DIVISOR_BITS'(count_eff);
                  state_in = ST_DIV;
               end
               MODE_LENGTH: begin
                  dvd_in   = seg_prod[PROD_BITS-1:PROD_BITS-DVD_BITS];
                  div_in   = DIVISOR_BITS'(radius_div);
                  state_in = ST_DIV;
               end
               MODE_ANGLE: begin
                  delta_in      = (incr_ff == '0) ? DEFAULT_DELTA : ANGLE_BITS'(incr_ff);
                  trig_load     = 1'b1;
                  start_pass_in = 1'b1;
                  state_in      = ST_TRIG;
               end
               default: begin
                  delta_in      = DEFAULT_DELTA;
                  trig_load     = 1'b1;
                  start_pass_in = 1'b1;
                  state_in      = ST_TRIG;
               end
            endcase
         end
         ST_DIV: begin
            rem_in = qbit ? trial_diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            dvd_in = quot_next;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(DVD_BITS - 1)) begin
               delta_in      = quot_sat;
               trig_load     = 1'b1;
               start_pass_in = 1'b1;
               state_in      = ST_TRIG;
            end
         end
         ST_TRIG: begin
            // One rotation iteration per cycle
            if (!z_ff[CORDIC_BITS-1]) begin
               x_in = x_ff - (y_ff >>> cnt_ff);
               y_in = y_ff + (x_ff >>> cnt_ff);
               z_in = z_ff - cordic_atan(cnt_ff);
            end else begin
               x_in = x_ff + (y_ff >>> cnt_ff);
               y_in = y_ff - (x_ff >>> cnt_ff);
               z_in = z_ff + cordic_atan(cnt_ff);
            end
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(TRIG_ITERATIONS - 1)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            mcx_in   = PROD_MAG_BITS'(magx);
            mcy_in   = PROD_MAG_BITS'(magy);
            sgnx_in  = signx;
            sgny_in  = signy;
            accx_in  = '0;
            accy_in  = '0;
            rad_in   = radius_ff;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // Shift-add over the radius bits, LSB first
            accx_in = accx_ff + (rad_ff[0] ? mcx_ff : '0);
            accy_in = accy_ff + (rad_ff[0] ? mcy_ff : '0);
            mcx_in  = mcx_ff << 1;
            mcy_in  = mcy_ff << 1;
            rad_in  = rad_ff >> 1;
            cnt_in  = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(RADIUS_BITS - 1)) begin
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            if (start_pass_ff) begin
               // Start point done; rotate to the first step
               prev_x_in     = pt_x;
               prev_y_in     = pt_y;
               angle_in      = {1'b0, delta_ff};
               trig_load     = 1'b1;
               trig_angle    = delta_ff;
               start_pass_in = 1'b0;
               state_in      = ST_TRIG;
            end else begin
               end_x_in = pt_x;
               end_y_in = pt_y;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               ox0_in       = prev_x_ff;
               oy0_in       = prev_y_ff;
               ox1_in       = end_x_ff;
               oy1_in       = end_y_ff;
               olast_in     = angle_ff[ANGLE_BITS];
               rsp_valid_in = 1'b1;
               prev_x_in    = end_x_ff;
               prev_y_in    = end_y_ff;
               turn_done_in = angle_ff[ANGLE_BITS];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Rotation unit load: quadrant from the top bits, residual phase below
      if (trig_load) begin
         x_in    = GAIN_Q30;
         y_in    = '0;
         z_in    = $signed({2'b00, trig_angle[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}});
         quad_in = trig_angle[ANGLE_BITS-1:ANGLE_BITS-2];
         cnt_in  = '0;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= RADIUS_BITS'(64);
         mode_ff     <= MODE_COUNT;
         count_ff    <= DEFAULT_COUNT;
         incr_ff     <= ANGLE_INC_BITS'(104);
         seglen_ff   <= DEFAULT_SEG_LEN;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CENTER_X:    center_x_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_CENTER_Y:    center_y_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_RADIUS:      radius_ff   <= csr_wdata[RADIUS_BITS-1:0];
            CSR_STEP_MODE:   mode_ff     <= csr_wdata[MODE_BITS-1:0];
            CSR_STEP_COUNT:  count_ff    <= csr_wdata[STEP_COUNT_BITS-1:0];
            CSR_ANGLE_INC:   incr_ff     <= csr_wdata[ANGLE_INC_BITS-1:0];
            CSR_MAX_SEG_LEN: seglen_ff   <= csr_wdata[SEG_LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         turn_done_ff  <= 1'b1;
         start_pass_ff <= 1'b0;
         angle_ff      <= '0;
         delta_ff      <= DEFAULT_DELTA;
         rsp_valid_ff  <= 1'b0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         turn_done_ff  <= turn_done_in;
         start_pass_ff <= start_pass_in;
         angle_ff      <= angle_in;
         delta_ff      <= delta_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      quad_ff  <= quad_in;
      mcx_ff   <= mcx_in;
      mcy_ff   <= mcy_in;
      accx_ff  <= accx_in;
      accy_ff  <= accy_in;
      sgnx_ff  <= sgnx_in;
      sgny_ff  <= sgny_in;
      rad_ff   <= rad_in;
      end_x_ff <= end_x_in;
      end_y_ff <= end_y_in;
      ox0_ff   <= ox0_in;
      oy0_ff   <= oy0_in;
      ox1_ff   <= ox1_in;
      oy1_ff   <= oy1_in;
      olast_ff <= olast_in;
   end

   // Checks
   a_fresh_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_restart || turn_done_ff)) |=> (state_ff == ST_PREP))
      else $error("fresh start did not enter step preparation");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   a_delta_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIG) |-> (delta_ff != '0))
      else $error("angle step is zero");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid_ff && (turn_done_ff == olast_ff)))
      else $error("turn flag and last flag disagree");

endmodule
